FILE: hw/rtl/fxalu_pkg.sv
// shared types, opcodes and the saturation helper for the fixed-point alu
package fxalu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
    localparam int MAG_W     = 2 * WORD_BITS;

    // opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MIN = 3'd4;
    localparam logic [2:0] OP_MAX = 3'd5;
    localparam logic [2:0] OP_INC = 3'd6;
    localparam logic [2:0] OP_DEC = 3'd7;

    typedef struct packed {
        logic [2:0]                  op;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result;
        logic                        greater;
        logic                        equal;
        logic                        less;
        logic                        fault;
    } t_out;

    // operand work carried into the multiplier
    typedef struct packed {
        logic [2:0]           op;
        logic [WORD_BITS-1:0] ma;
        logic [WORD_BITS-1:0] mb;
        logic                 neg;
        logic [WORD_BITS-1:0] res;
        logic                 gt;
        logic                 eq;
        logic                 lt;
        logic                 dz;
    } t_work;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic [2:0]           op;
        logic                 neg;
        logic [WORD_BITS-1:0] res;
        logic                 gt;
        logic                 eq;
        logic                 lt;
        logic                 fault;
        logic                 dz;
    } t_side;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 ovf;
    } t_sat;

    // clamp a magnitude to the signed word range and apply the sign
    function automatic t_sat sat_word(input logic [MAG_W-1:0] mag, input logic neg);
        logic [MAG_W-1:0]     limit;
        logic [WORD_BITS-1:0] v;
        t_sat                 s;
        limit = neg ? (MAG_W'(1) << (WORD_BITS - 1))
                    : ((MAG_W'(1) << (WORD_BITS - 1)) - MAG_W'(1));
        s.ovf = mag > limit;
        v     = s.ovf ? limit[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        s.val = neg ? (~v + WORD_BITS'(1)) : v;
        return s;
    endfunction

endpackage

FILE: hw/rtl/fxalu_mul.sv
// two-stage multiplier: magnitude product, then rounding and saturation
module fxalu_mul
    import fxalu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_work                i_work,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_ma,
    output logic [WORD_BITS-1:0] o_mb,
    output t_side                o_side
);

    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FRAC_BITS - 1);

    logic             r_pv;
    logic [MAG_W-1:0] r_prod;
    t_work            r_pw;
    logic             r_ov;
    logic [WORD_BITS-1:0] r_ma;
    logic [WORD_BITS-1:0] r_mb;
    t_side            r_side;
    logic [MAG_W-1:0] rounded;
    t_sat             sat;
    t_side            n_side;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
        if (i_en) begin
            r_prod <= MAG_W'(i_work.ma) * MAG_W'(i_work.mb);
            r_pw   <= i_work;
        end
    end

    // round half away from zero on the magnitude, then clamp
    always_comb begin
        rounded = (r_prod + HALF) >> FRAC_BITS;
        sat     = sat_word(rounded, r_pw.neg);
        n_side.op    = r_pw.op;
        n_side.neg   = r_pw.neg;
        n_side.res   = r_pw.res;
        n_side.gt    = r_pw.gt;
        n_side.eq    = r_pw.eq;
        n_side.lt    = r_pw.lt;
        n_side.fault = 1'b0;
        n_side.dz    = r_pw.dz;
        if (r_pw.op == OP_MUL) begin
            n_side.res   = sat.val;
            n_side.fault = sat.ovf;
        end
    end

    // rounding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_pv;
        end
        if (i_en) begin
            r_side <= n_side;
            r_ma   <= r_pw.ma;
            r_mb   <= r_pw.mb;
        end
    end

    assign o_valid = r_ov;
    assign o_ma    = r_ma;
    assign o_mb    = r_mb;
    assign o_side  = r_side;

endmodule

FILE: hw/rtl/fxalu_div.sv
// restoring divider, one quotient bit per pipeline stage
module fxalu_div
    import fxalu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [QUO_BITS-1:0]  i_nq,
    input  logic [WORD_BITS-1:0] i_d,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [QUO_BITS-1:0]  o_q,
    output logic [WORD_BITS-1:0] o_rem,
    output logic [WORD_BITS-1:0] o_d,
    output t_side                o_side
);

    logic                 s_v    [0:QUO_BITS];
    logic [QUO_BITS-1:0]  s_nq   [0:QUO_BITS];
    logic [WORD_BITS-1:0] s_rem  [0:QUO_BITS];
    logic [WORD_BITS-1:0] s_d    [0:QUO_BITS];
    t_side                s_side [0:QUO_BITS];

    assign s_v[0]    = i_valid;
    assign s_nq[0]   = i_nq;
    assign s_rem[0]  = '0;
    assign s_d[0]    = i_d;
    assign s_side[0] = i_side;

    // numerator bits shift out of the top while quotient bits shift in below
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        logic                 r_v;
        logic [QUO_BITS-1:0]  r_nq;
        logic [WORD_BITS-1:0] r_rem;
        logic [WORD_BITS-1:0] r_d;
        t_side                r_side;
        logic [WORD_BITS:0]   rem_sh;
        logic [WORD_BITS:0]   diff;
        logic                 ge;

        always_comb begin
            rem_sh = {s_rem[k], s_nq[k][QUO_BITS-1]};
            diff   = rem_sh - {1'b0, s_d[k]};
            ge     = rem_sh >= {1'b0, s_d[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
            if (i_en) begin
                r_nq   <= {s_nq[k][QUO_BITS-2:0], ge};
                r_rem  <= ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
                r_d    <= s_d[k];
                r_side <= s_side[k];
            end
        end

        assign s_v[k+1]    = r_v;
        assign s_nq[k+1]   = r_nq;
        assign s_rem[k+1]  = r_rem;
        assign s_d[k+1]    = r_d;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_v[QUO_BITS];
    assign o_q     = s_nq[QUO_BITS];
    assign o_rem   = s_rem[QUO_BITS];
    assign o_d     = s_d[QUO_BITS];
    assign o_side  = s_side[QUO_BITS];

endmodule

FILE: hw/rtl/fixed_point_q24_8_alu_top.sv
// signed Q24.8 fixed-point alu, fully pipelined
// Usage: a request (op, operand_a, operand_b) enters on i_in_valid/i_in_data
// and is taken at a clock edge where o_in_stall is low. Each request gives
// exactly one result on o_out_valid/o_out_data, taken where i_out_stall is low.
// Ops: add, sub, mul, div, min, max, increment and decrement of operand_a.
// Add, sub and the steps wrap; mul and div round half away from zero and
// clamp to the word range with fault set; divide by zero gives 0 with fault.
// The compare flags are returned for every op.
// A request is caught in the input register at the accepting edge, then
// passes operand prep, product, rounding, 40 divider stages of one quotient
// bit each and the output register to o_out_valid. Throughput: one request
// per cycle while i_out_stall is not holding a result; every op walks the
// same path.
// A receiver stall freezes the whole pipeline while a result waits, and
// o_in_stall follows it in the same cycle; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is not reset.
module fixed_point_q24_8_alu_top
    import fxalu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic  en;
    logic  r_s1_valid;
    t_in   r_s1;
    logic  r_s2_valid;
    t_work r_s2;
    t_work n_s2;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;

    logic                 mul_valid;
    logic [WORD_BITS-1:0] mul_ma;
    logic [WORD_BITS-1:0] mul_mb;
    t_side                mul_side;

    logic                 div_valid;
    logic [QUO_BITS-1:0]  div_q;
    logic [WORD_BITS-1:0] div_rem;
    logic [WORD_BITS-1:0] div_d;
    t_side                div_side;

    logic                 rnd;
    logic [QUO_BITS:0]    q_rnd;
    t_sat                 div_sat;
    t_out                 n_out;
    logic                 r_out_valid;
    t_out                 r_out;

    // whole pipeline moves unless a finished result is held
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
        if (en) begin
            r_s1 <= i_in_data;
        end
    end

    // operand prep: magnitudes, flags and the simple ops
    always_comb begin
        a = r_s1.operand_a;
        b = r_s1.operand_b;
        n_s2.op  = r_s1.op;
        n_s2.ma  = a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
        n_s2.mb  = b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b;
        n_s2.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        n_s2.gt  = r_s1.operand_a > r_s1.operand_b;
        n_s2.lt  = r_s1.operand_a < r_s1.operand_b;
        n_s2.eq  = a == b;
        n_s2.dz  = b == '0;
        case (r_s1.op)
            OP_ADD:  n_s2.res = a + b;
            OP_SUB:  n_s2.res = a - b;
            OP_MIN:  n_s2.res = n_s2.lt ? a : b;
            OP_MAX:  n_s2.res = n_s2.gt ? a : b;
            OP_INC:  n_s2.res = a + WORD_BITS'(1);
            OP_DEC:  n_s2.res = a - WORD_BITS'(1);
            default: n_s2.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en) begin
            r_s2 <= n_s2;
        end
    end

    fxalu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_valid),
        .i_work  (r_s2),
        .o_valid (mul_valid),
        .o_ma    (mul_ma),
        .o_mb    (mul_mb),
        .o_side  (mul_side)
    );

    // numerator is the dividend magnitude shifted up by the fraction width
    fxalu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_valid),
        .i_nq    ({mul_ma, FRAC_BITS'(0)}),
        .i_d     (mul_mb),
        .i_side  (mul_side),
        .o_valid (div_valid),
        .o_q     (div_q),
        .o_rem   (div_rem),
        .o_d     (div_d),
        .o_side  (div_side)
    );

    // quotient rounding, clamp and final selection
    always_comb begin
        rnd     = {div_rem, 1'b0} >= {1'b0, div_d};
        q_rnd   = {1'b0, div_q} + (QUO_BITS + 1)'(rnd);
        div_sat = sat_word(MAG_W'(q_rnd), div_side.neg);
        n_out.result  = div_side.res;
        n_out.greater = div_side.gt;
        n_out.equal   = div_side.eq;
        n_out.less    = div_side.lt;
        n_out.fault   = div_side.fault;
        if (div_side.op == OP_DIV) begin
            if (div_side.dz) begin
                n_out.result = '0;
                n_out.fault  = 1'b1;
            end else begin
                n_out.result = div_sat.val;
                n_out.fault  = div_sat.ovf;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // a held result must hold back new requests
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request accepted while result held");

    // flags are mutually exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones({o_out_data.greater, o_out_data.equal,
                                     o_out_data.less}) == 1))
        else $error("compare flags not exclusive");

    // fault only from mul or div
    a_fault_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_valid && div_side.op != OP_MUL && div_side.op != OP_DIV) |-> !n_out.fault)
        else $error("fault on non mul/div op");

    // valid cleared the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
